FILE: rtl/core/path_corridor_merge_defines.svh
// Assertion macros used by the checker of the corridor merge block.
// Depends on nothing; the including module must provide clk and rst.
`ifndef PATH_CORRIDOR_MERGE_DEFINES_SVH
`define PATH_CORRIDOR_MERGE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pcm_pkg.sv
`timescale 1ns / 1ps
// Types and codes shared by the corridor merge block and its checker.
// Depends on nothing.
package pcm_pkg;

  localparam int REF_W = 32;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_CORRIDOR = 2'd1;
  localparam logic [1:0] REQ_VISITED  = 2'd2;
  localparam logic [1:0] REQ_READ     = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [REF_W-1:0] poly_ref;
    logic [7:0]       read_index;
    logic             last_visited;
  } req_t;

  typedef struct packed {
    logic [8:0]       corridor_count;
    logic [REF_W-1:0] read_ref;
    logic [1:0]       status;
  } rsp_t;

  // Shift controls for the visited cell row.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

FILE: rtl/core/pcm_cell.sv
`timescale 1ns / 1ps
// One cell of the visited row: holds one polygon reference and compares it.
// Depends on pcm_pkg.
module pcm_cell
  import pcm_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [REF_W-1:0] left_data,
  input  logic [REF_W-1:0] right_data,
  input  logic [REF_W-1:0] key,
  output logic [REF_W-1:0] data,
  output logic             hit
);

  // A push moves the row away from cell 0, a pop moves it toward cell 0.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= left_data;
    end else if (ctl.pop) begin
      data <= right_data;
    end
  end

  assign hit = (data == key);

endmodule

FILE: rtl/core/path_corridor_merge.sv
`timescale 1ns / 1ps
// Corridor merge top level. Clear, corridor append and plain visited append give their
// result in the cycle after acceptance; a read gives it after the registered memory read
// and the read state. A merge scans the corridor, moves the kept entries and prepends the
// visited entries, paced by the single write port and single read port of the corridor
// memory. Synchronous active-high reset empties both lists and idles the block.
// Depends on pcm_pkg and pcm_cell.
module path_corridor_merge
  import pcm_pkg::*;
#(
  parameter int CORRIDOR_DEPTH = 256,
  parameter int VISITED_DEPTH  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  // Address, length and helper widths, all derived from the depths.
  localparam int AW  = $clog2(CORRIDOR_DEPTH);
  localparam int LW  = $clog2(CORRIDOR_DEPTH + 1);
  localparam int VW  = $clog2(VISITED_DEPTH + 1);
  localparam int CW  = (VISITED_DEPTH > 1) ? $clog2(VISITED_DEPTH) : 1;
  localparam int GW  = ((LW > VW) ? LW : VW) + 1;
  localparam int XW  = (LW > 8) ? LW : 8;
  localparam int CXW = (LW > 9) ? LW : 9;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_PREPEND = 3'd4;

  // The count port shows the length masked to nine bits.
  function automatic logic [8:0] count_out(input logic [LW-1:0] v);
    logic [CXW-1:0] w;
    w = CXW'(v);
    return w[8:0];
  endfunction

  logic [2:0]    state;
  logic [LW-1:0] len;
  logic [VW-1:0] vlen;
  logic          full_flag;

  // Corridor memory: one write and one registered read per cycle.
  logic [REF_W-1:0] mem [CORRIDOR_DEPTH];
  logic [REF_W-1:0] mem_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [REF_W-1:0] wr_data;

  // Search pipeline: issue, memory read, registered match vector.
  logic [LW-1:0]            ptr;
  logic                     s1_valid;
  logic [AW-1:0]            s1_idx;
  logic                     s2_valid;
  logic [AW-1:0]            s2_idx;
  logic [VISITED_DEPTH-1:0] mvec;

  // Move and prepend bookkeeping.
  logic [LW-1:0] lead_c;
  logic [LW-1:0] new_len;
  logic [LW-1:0] mv_left;
  logic          move_up;
  logic [AW-1:0] src;
  logic [AW-1:0] dst;
  logic          pend_valid;
  logic [AW-1:0] pend_dst;
  logic [LW-1:0] pp;

  // Visited row. Cell i holds the entry appended i appends ago, so the row
  // read from cell 0 upward is the visited list in reverse order, which is
  // exactly the prefix the merge puts in front of the corridor.
  cell_ctl_t                cell_ctl;
  logic [REF_W-1:0]         cell_data  [VISITED_DEPTH];
  logic [REF_W-1:0]         left_bus   [VISITED_DEPTH];
  logic [REF_W-1:0]         right_bus  [VISITED_DEPTH];
  logic [VISITED_DEPTH-1:0] cell_hit;
  logic [VISITED_DEPTH-1:0] live_hit;

  for (genvar g = 0; g < VISITED_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_bus[g] = request.poly_ref;
    end else begin : g_inner_left
      assign left_bus[g] = cell_data[g-1];
    end
    if (g == VISITED_DEPTH - 1) begin : g_last
      assign right_bus[g] = '0;
    end else begin : g_inner_right
      assign right_bus[g] = cell_data[g+1];
    end
    pcm_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .left_data  (left_bus[g]),
      .right_data (right_bus[g]),
      .key        (mem_q),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  // Only cells below the visited length take part in a match.
  always_comb begin
    for (int i = 0; i < VISITED_DEPTH; i++) begin
      live_hit[i] = cell_hit[i] && (VW'(i) < vlen);
    end
  end

  // The lowest visited index that matched is the highest matching cell.
  logic [CW-1:0] top_cell;
  always_comb begin
    top_cell = '0;
    for (int i = 0; i < VISITED_DEPTH; i++) begin
      if (mvec[i]) top_cell = CW'(i);
    end
  end

  // Merge plan, worked out when the search reports a hit.
  logic          hit;
  logic [GW-1:0] lead_w, start_w, rest_w, depth_w, lead_cw, room_w, rest_cw;
  always_comb begin
    hit     = s2_valid && (mvec != '0);
    lead_w  = GW'(top_cell) + GW'(1);
    start_w = GW'(s2_idx) + GW'(1);
    rest_w  = GW'(len) - start_w;
    depth_w = GW'(CORRIDOR_DEPTH);
    lead_cw = (lead_w > depth_w) ? depth_w : lead_w;
    room_w  = depth_w - lead_cw;
    rest_cw = (rest_w > room_w) ? room_w : rest_w;
  end

  // Request decode in the idle state.
  logic          accept;
  logic          c_full;
  logic          v_full;
  logic [XW-1:0] idx_w;
  logic          idx_ok;
  assign accept = start && !busy;
  assign c_full = (len == LW'(CORRIDOR_DEPTH));
  assign v_full = (vlen == VW'(VISITED_DEPTH));
  assign idx_w  = XW'(request.read_index);
  assign idx_ok = idx_w < XW'(len);

  assign busy = (state != S_IDLE);

  always_comb begin
    cell_ctl.push = (state == S_IDLE) && accept && (request.req_type == REQ_VISITED)
                    && !v_full;
    cell_ctl.pop  = (state == S_PREPEND);
  end

  // Memory port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(len);
    wr_data = request.poly_ref;
    rd_addr = idx_w[AW-1:0];
    unique case (state)
      S_IDLE: begin
        wr_en = accept && (request.req_type == REQ_CORRIDOR) && !c_full;
      end
      S_SEARCH: begin
        rd_addr = AW'(ptr - 1'b1);
      end
      S_MOVE: begin
        rd_addr = src;
        wr_en   = pend_valid;
        wr_addr = pend_dst;
        wr_data = mem_q;
      end
      S_PREPEND: begin
        wr_en   = 1'b1;
        wr_addr = AW'(pp);
        wr_data = cell_data[0];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      vlen       <= '0;
      done       <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      done     <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result.read_ref <= '0;
            result.status   <= ST_OK;
            unique case (request.req_type)
              REQ_CLEAR: begin
                len                   <= '0;
                vlen                  <= '0;
                done                  <= 1'b1;
                result.corridor_count <= '0;
              end
              REQ_CORRIDOR: begin
                done <= 1'b1;
                if (c_full) begin
                  result.corridor_count <= count_out(len);
                  result.status         <= ST_FULL;
                end else begin
                  len                   <= len + 1'b1;
                  result.corridor_count <= count_out(len + 1'b1);
                end
              end
              REQ_VISITED: begin
                if (!v_full) begin
                  vlen <= vlen + 1'b1;
                end
                if (request.last_visited) begin
                  // The cells take the new entry at this edge unless the row is full;
                  // the scan starts from the corridor's end in the next cycle.
                  full_flag <= v_full;
                  ptr       <= len;
                  state     <= S_SEARCH;
                end else begin
                  done                  <= 1'b1;
                  result.corridor_count <= count_out(len);
                  result.status         <= v_full ? ST_FULL : ST_OK;
                end
              end
              REQ_READ: begin
                result.corridor_count <= count_out(len);
                if (idx_ok) begin
                  state <= S_READ;
                end else begin
                  done          <= 1'b1;
                  result.status <= ST_RANGE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          done            <= 1'b1;
          result.read_ref <= mem_q;
          state           <= S_IDLE;
        end
        S_SEARCH: begin
          // One corridor entry enters the scan per cycle, last entry first.
          if (ptr != '0) begin
            s1_valid <= 1'b1;
            s1_idx   <= AW'(ptr - 1'b1);
            ptr      <= ptr - 1'b1;
          end
          s2_valid <= s1_valid;
          s2_idx   <= s1_idx;
          mvec     <= live_hit;
          if (hit) begin
            s1_valid <= 1'b0;
            s2_valid <= 1'b0;
            lead_c   <= LW'(lead_cw);
            new_len  <= LW'(lead_cw + rest_cw);
            pp       <= '0;
            move_up  <= lead_cw > start_w;
            if (lead_cw == start_w) begin
              mv_left <= '0;
            end else begin
              mv_left <= LW'(rest_cw);
            end
            // Moving up runs from the top down, moving down from the bottom
            // up, so no entry is overwritten before it is read.
            if (lead_cw > start_w) begin
              src <= AW'(start_w + rest_cw - GW'(1));
              dst <= AW'(lead_cw + rest_cw - GW'(1));
            end else begin
              src <= AW'(start_w);
              dst <= AW'(lead_cw);
            end
            state <= S_MOVE;
          end else if (ptr == '0 && !s1_valid && !s2_valid) begin
            // Nothing matched: corridor kept, visited list emptied.
            vlen                  <= '0;
            done                  <= 1'b1;
            result.corridor_count <= count_out(len);
            result.read_ref       <= '0;
            result.status         <= full_flag ? ST_FULL : ST_NOMATCH;
            state                 <= S_IDLE;
          end
        end
        S_MOVE: begin
          if (mv_left != '0) begin
            pend_valid <= 1'b1;
            pend_dst   <= dst;
            src        <= move_up ? src - 1'b1 : src + 1'b1;
            dst        <= move_up ? dst - 1'b1 : dst + 1'b1;
            mv_left    <= mv_left - 1'b1;
          end else begin
            pend_valid <= 1'b0;
            if (!pend_valid) begin
              state <= S_PREPEND;
            end
          end
        end
        S_PREPEND: begin
          // Cell 0 is written to the next front slot while the row shifts.
          pp <= pp + 1'b1;
          if (pp == lead_c - 1'b1) begin
            len                   <= new_len;
            vlen                  <= '0;
            done                  <= 1'b1;
            result.corridor_count <= count_out(new_len);
            result.read_ref       <= '0;
            result.status         <= full_flag ? ST_FULL : ST_OK;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/pcm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the corridor merge block, bound to its top level.
// Depends on pcm_pkg and path_corridor_merge_defines.svh.
`include "path_corridor_merge_defines.svh"

module pcm_checker
  import pcm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t request,
  input logic done,
  input rsp_t result
);

  // An accepted item either finishes at once or keeps the block busy.
  `PCM_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted item lost")

  // A result is only given once the block is idle again.
  `PCM_ASSERT_SAME(a_done_idle, done, !busy, "result while busy")

  // A clear empties the corridor and reports right away.
  `PCM_ASSERT_NEXT(a_clear_result, start && !busy && request.req_type == REQ_CLEAR,
    done && result.corridor_count == 9'd0 && result.status == ST_OK, "clear result wrong")

  // Read data shows only on a good read.
  `PCM_ASSERT_SAME(a_read_ref_ok, done && result.read_ref != '0, result.status == ST_OK,
    "read data with bad status")

endmodule

bind path_corridor_merge pcm_checker u_pcm_checker (.*);

FILE: sim/corridor_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the corridor merge block: a predictor of the corridor and
// visited lists and a queue of expected responses. Depends on pcm_pkg.
package corridor_sb_pkg;
  import pcm_pkg::*;

  localparam int CORRIDOR_DEPTH = 256;
  localparam int VISITED_DEPTH  = 16;

  class corridor_scoreboard;
    logic [REF_W-1:0] corridor [CORRIDOR_DEPTH];
    logic [REF_W-1:0] visited [VISITED_DEPTH];
    int unsigned      corridor_len;
    int unsigned      visited_len;
    rsp_t             expected_rsps [$];
    int unsigned      errors;

    function new();
      corridor_len = 0;
      visited_len  = 0;
      errors       = 0;
    endfunction

    function int unsigned pending();
      return expected_rsps.size();
    endfunction

    // Rebuilds the corridor around the furthest entry that any visited entry
    // matches. Returns 0 and leaves the corridor alone when nothing matches.
    function bit merge_visited();
      logic [REF_W-1:0] rebuilt [CORRIDOR_DEPTH];
      int unsigned hit_c, hit_v, lead, rest, first;
      bit found;
      found = 0;
      hit_c = 0;
      hit_v = 0;
      for (int i = corridor_len; i > 0; i--) begin
        if (!found) begin
          for (int j = 0; j < visited_len; j++) begin
            if (!found && corridor[i-1] == visited[j]) begin
              hit_c = i - 1;
              hit_v = j;
              found = 1;
            end
          end
        end
      end
      if (!found) return 0;
      lead  = visited_len - hit_v;
      first = hit_c + 1;
      rest  = corridor_len - first;
      if (lead > CORRIDOR_DEPTH) lead = CORRIDOR_DEPTH;
      if (lead + rest > CORRIDOR_DEPTH) rest = CORRIDOR_DEPTH - lead;
      rebuilt = corridor;
      for (int k = 0; k < rest; k++) rebuilt[lead+k] = corridor[first+k];
      for (int k = 0; k < lead; k++) rebuilt[k] = visited[visited_len-1-k];
      corridor     = rebuilt;
      corridor_len = lead + rest;
      return 1;
    endfunction

    // Applies one accepted request to the predicted state and queues the
    // response that it must produce.
    function void note_request(req_t rq);
      rsp_t rsp;
      rsp.status   = ST_OK;
      rsp.read_ref = '0;
      case (rq.req_type)
        REQ_CLEAR: begin
          corridor_len = 0;
          visited_len  = 0;
        end
        REQ_CORRIDOR: begin
          if (corridor_len < CORRIDOR_DEPTH) begin
            corridor[corridor_len] = rq.poly_ref;
            corridor_len++;
          end else begin
            rsp.status = ST_FULL;
          end
        end
        REQ_VISITED: begin
          if (visited_len < VISITED_DEPTH) begin
            visited[visited_len] = rq.poly_ref;
            visited_len++;
          end else begin
            rsp.status = ST_FULL;
          end
          if (rq.last_visited) begin
            if (!merge_visited() && rsp.status == ST_OK) rsp.status = ST_NOMATCH;
            visited_len = 0;
          end
        end
        default: begin
          if (rq.read_index < corridor_len) rsp.read_ref = corridor[rq.read_index];
          else rsp.status = ST_RANGE;
        end
      endcase
      rsp.corridor_count = corridor_len[8:0];
      expected_rsps = {expected_rsps, rsp};
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsps.size() == 0) begin
        $error("response with none expected: count %0d ref %h status %0d",
               got.corridor_count, got.read_ref, got.status);
        errors++;
        return;
      end
      want = expected_rsps.pop_front();
      if (got.corridor_count !== want.corridor_count) begin
        $error("corridor_count: expected %0d, actual %0d",
               want.corridor_count, got.corridor_count);
        errors++;
      end
      if (got.read_ref !== want.read_ref) begin
        $error("read_ref: expected %h, actual %h", want.read_ref, got.read_ref);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for path_corridor_merge: directed and random requests
// checked against a scoreboard model. Depends on pcm_pkg and corridor_sb_pkg.
module tb_top;
  import pcm_pkg::*;
  import corridor_sb_pkg::*;

  // A merge over a full corridor runs without a response, and the sender idles
  // between items, but neither comes near this limit, so a stretch this
  // long with no handshake at all means the block has hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Cycles to keep watching after the last response, enough for a full merge.
  localparam int TAIL_CYCLES    = 600;
  localparam int RANDOM_ITEMS   = 380;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t request;
  rsp_t result;

  corridor_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          no_idle;

  path_corridor_merge #(
    .CORRIDOR_DEPTH(CORRIDOR_DEPTH),
    .VISITED_DEPTH (VISITED_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .done   (done),
    .result (result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Responses are sampled at the edge that ends their strobe cycle, so the
  // values seen here are the ones the block drove during that cycle. The same
  // block runs the watchdog: any accepted item or response restarts the count.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_response(result);
      if ((start && !busy) || done) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offers one item and holds it until the block accepts it. An optional idle
  // gap comes first; start is only lowered when a gap is actually taken, so a
  // back-to-back item never sees start dropped and raised in one step.
  task automatic send_item(req_t item);
    if (!no_idle && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= item;
    do @(posedge clk); while (busy);
    sb.note_request(item);
    items_sent++;
  endtask

  // Fields that a request type does not use are filled with random values,
  // which also exercises the last mark on types that must ignore it.
  task automatic do_clear();
    req_t item;
    item.req_type     = REQ_CLEAR;
    item.poly_ref     = $urandom;
    item.read_index   = 8'($urandom_range(255));
    item.last_visited = 1'($urandom_range(1));
    send_item(item);
  endtask

  task automatic do_corridor(logic [REF_W-1:0] poly);
    req_t item;
    item.req_type     = REQ_CORRIDOR;
    item.poly_ref     = poly;
    item.read_index   = 8'($urandom_range(255));
    item.last_visited = 1'($urandom_range(1));
    send_item(item);
  endtask

  task automatic do_visited(logic [REF_W-1:0] poly, logic last);
    req_t item;
    item.req_type     = REQ_VISITED;
    item.poly_ref     = poly;
    item.read_index   = 8'($urandom_range(255));
    item.last_visited = last;
    send_item(item);
  endtask

  task automatic do_read(logic [7:0] idx);
    req_t item;
    item.req_type     = REQ_READ;
    item.poly_ref     = $urandom;
    item.read_index   = idx;
    item.last_visited = 1'($urandom_range(1));
    send_item(item);
  endtask

  // Holds the sender off until every queued response has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A typical move: optionally clear, lay down a short corridor, then report
  // the visited polygons with the last mark on the final one, and read back.
  // References come mostly from a small pool so that matches are common. Now
  // and then the visited list runs past its capacity.
  task automatic merge_sequence();
    logic [REF_W-1:0] pool [6];
    int unsigned n_corr, n_vis;
    foreach (pool[k]) pool[k] = $urandom;
    if ($urandom_range(99) < 70) do_clear();
    n_corr = $urandom_range(0, 20);
    n_vis  = ($urandom_range(9) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 8);
    repeat (n_corr) begin
      if ($urandom_range(4) == 0) do_corridor($urandom);
      else do_corridor(pool[$urandom_range(5)]);
    end
    for (int k = 1; k <= n_vis; k++) begin
      if ($urandom_range(4) == 0) do_visited($urandom, k == n_vis);
      else do_visited(pool[$urandom_range(5)], k == n_vis);
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(7) == 0) do_read(8'($urandom_range(255)));
      else do_read(8'($urandom_range(0, 24)));
    end
  endtask

  // Fills the corridor past capacity, then merges a full visited list whose
  // match sits near the front, so the rebuilt corridor is usually clipped. A
  // second visited list then overflows its capacity on its last-marked entry.
  task automatic full_sequence();
    logic [REF_W-1:0] head [4];
    int unsigned hit_pos;
    foreach (head[k]) head[k] = $urandom;
    do_clear();
    for (int k = 0; k < CORRIDOR_DEPTH + 3; k++) begin
      if (k < 4) do_corridor(head[k]);
      else do_corridor($urandom);
    end
    do_read(8'd0);
    do_read(8'd255);
    hit_pos = $urandom_range(0, VISITED_DEPTH - 1);
    for (int k = 0; k < VISITED_DEPTH; k++)
      do_visited((k == hit_pos) ? head[1] : $urandom, k == VISITED_DEPTH - 1);
    do_read(8'd0);
    do_read(8'd255);
    for (int k = 0; k <= VISITED_DEPTH; k++)
      do_visited((k == 3) ? head[2] : $urandom, k == VISITED_DEPTH);
    do_read(8'd17);
  endtask

  // Fully random requests of every type and field value.
  task automatic noise_burst();
    req_t item;
    repeat ($urandom_range(1, 6)) begin
      item.req_type     = 2'($urandom_range(3));
      item.poly_ref     = $urandom;
      item.read_index   = 8'($urandom_range(255));
      item.last_visited = 1'($urandom_range(1));
      send_item(item);
    end
  endtask

  initial begin
    int unsigned goal;
    bit          filled;
    bit          drained;

    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    items_sent   = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    filled       = 1'b0;
    drained      = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reads on an empty corridor and past its end, both
    // extreme references, a merge with a match, a merge with none, and a
    // merge where two visited entries match different corridor positions.
    do_clear();
    do_read(8'd0);
    do_corridor(32'h0000_0000);
    do_corridor(32'hFFFF_FFFF);
    do_corridor(32'h0000_0005);
    do_corridor(32'h0000_0007);
    do_read(8'd0);
    do_read(8'd1);
    do_read(8'd3);
    do_read(8'd4);
    do_read(8'd255);
    do_visited(32'h0000_0009, 1'b0);
    do_visited(32'h0000_0005, 1'b1);
    do_read(8'd0);
    do_read(8'd1);
    do_visited(32'h0000_0033, 1'b1);
    do_visited(32'hFFFF_FFFF, 1'b0);
    do_visited(32'h0000_0007, 1'b0);
    do_visited(32'h0000_0005, 1'b1);
    do_read(8'd0);
    do_read(8'd1);
    do_clear();

    // Random part, mostly well-formed moves with noise in between. One
    // window of items runs with no idle gaps at all.
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      no_idle = (items_sent >= 40 && items_sent < 100);
      if (!filled && items_sent > 100) begin
        full_sequence();
        filled = 1'b1;
      end else if ($urandom_range(99) < 75) begin
        merge_sequence();
      end else begin
        noise_burst();
      end
      if ((!drained && items_sent > 60) || $urandom_range(9) == 0) begin
        drain();
        drained = 1'b1;
      end
    end
    no_idle = 1'b0;

    // Wind down: no more items, collect every response, then keep watching
    // long enough for a stray late response to show up.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pcm_pkg.sv
rtl/core/pcm_cell.sv
rtl/core/path_corridor_merge.sv
rtl/core/pcm_checker.sv
sim/corridor_sb_pkg.sv
sim/tb_top.sv
